@@ rtl/core/otl_pkg.sv @@
// shared types, constants and helpers for the operator table lookup
`default_nettype none
package otl_pkg;

  localparam int BUCKETS = 32;
  localparam int ENTRIES = 256;

  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int PTR_W   = $clog2(ENTRIES + 1);
  localparam int NAME_W  = 16;
  localparam int LEVEL_W = 16;
  localparam int TYPE_W  = 3;
  localparam int MODE_W  = 2;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [BKT_W-1:0]   bkt_t;
  typedef logic [NAME_W-1:0]  name_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [TYPE_W-1:0]  optype_t;
  typedef logic [1:0]         pos_t;

  localparam ptr_t NIL = PTR_W'(ENTRIES);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_LEVEL = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  localparam optype_t OP_FX  = 3'd0;
  localparam optype_t OP_FY  = 3'd1;
  localparam optype_t OP_XFX = 3'd2;
  localparam optype_t OP_XFY = 3'd3;
  localparam optype_t OP_YFX = 3'd4;
  localparam optype_t OP_XF  = 3'd5;
  localparam optype_t OP_YF  = 3'd6;

  localparam pos_t POS_PREFIX = 2'd0;
  localparam pos_t POS_INFIX  = 2'd1;
  localparam pos_t POS_SUFFIX = 2'd2;

  typedef struct packed {
    name_t                    name;
    ptr_t                     next;
    logic [2:0][LEVEL_W-1:0]  levels;
    logic [2:0][TYPE_W-1:0]   types;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic issue_read;
    logic hit;
    logic advance;
    logic act;
  } cmd_t;

  typedef struct packed {
    logic ptr_ok;
    logic name_match;
    logic out_free;
  } sts_t;

  function automatic pos_t pos_of(optype_t t);
    pos_t p;
    if (t <= OP_FY) begin
      p = POS_PREFIX;
    end else if (t >= OP_XF) begin
      p = POS_SUFFIX;
    end else begin
      p = POS_INFIX;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/otl_if.sv @@
// request and response channel interfaces
`default_nettype none
interface otl_req_if;
  logic                        valid;
  logic                        ready;
  logic [otl_pkg::MODE_W-1:0]  mode;
  logic [otl_pkg::NAME_W-1:0]  name_id;
  logic [otl_pkg::TYPE_W-1:0]  op_type;
  logic [otl_pkg::LEVEL_W-1:0] op_level;
  logic [otl_pkg::LEVEL_W-1:0] min_level;

  modport source (output valid, mode, name_id, op_type, op_level, min_level, input ready);
  modport sink   (input valid, mode, name_id, op_type, op_level, min_level, output ready);
endinterface

interface otl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [otl_pkg::LEVEL_W-1:0] result_level;
  logic                        answer_flag;
  logic                        table_full;

  modport source (output valid, result_level, answer_flag, table_full, input ready);
  modport sink   (input valid, result_level, answer_flag, table_full, output ready);
endinterface
`default_nettype wire

@@ rtl/core/operator_table_hash_lookup.sv @@
// top level of the operator table with chained hash lookup
//
//   port  dir   transaction
//   req   in    mode, name_id, op_type, op_level, min_level
//   rsp   out   result_level, answer_flag, table_full
//
// one request at a time; a request checks the chain pointer, reads the entry through
// the registered read port and compares its name, following next on a mismatch,
// until the name is found or the chain ends, then takes the update step
// a response waits in its output register while the next request is taken
// rst is synchronous and empties all buckets at once; entries need no clearing
// rsp stalls hold the update step until the output register frees
`default_nettype none
module operator_table_hash_lookup (
  input  wire logic clk,
  input  wire logic rst,
  otl_req_if.sink   req,
  otl_rsp_if.source rsp
);

  otl_pkg::cmd_t cmd;
  otl_pkg::sts_t sts;

  otl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  otl_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (req.mode),
    .name_id      (req.name_id),
    .op_type      (req.op_type),
    .op_level     (req.op_level),
    .min_level    (req.min_level),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .result_level (rsp.result_level),
    .answer_flag  (rsp.answer_flag),
    .table_full   (rsp.table_full)
  );

endmodule
`default_nettype wire

@@ rtl/core/otl_ctrl.sv @@
// sequencing state machine for the chain walk and table update
`default_nettype none
module otl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire otl_pkg::sts_t sts,
  output otl_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_ACT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.ptr_ok) begin
          cmd.issue_read = 1'b1;
          state_next     = ST_READ;
        end else begin
          state_next = ST_ACT;
        end
      end
      ST_READ: begin
        if (sts.name_match) begin
          cmd.hit    = 1'b1;
          state_next = ST_ACT;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_ACT: begin
        if (sts.out_free) begin
          cmd.act    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/otl_dpath.sv @@
// bucket heads, entry memory, chain pointer and result register
`default_nettype none
module otl_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire otl_pkg::cmd_t               cmd,
  output otl_pkg::sts_t                    sts,
  input  wire logic [otl_pkg::MODE_W-1:0]  mode,
  input  wire logic [otl_pkg::NAME_W-1:0]  name_id,
  input  wire logic [otl_pkg::TYPE_W-1:0]  op_type,
  input  wire logic [otl_pkg::LEVEL_W-1:0] op_level,
  input  wire logic [otl_pkg::LEVEL_W-1:0] min_level,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [otl_pkg::LEVEL_W-1:0]      result_level,
  output logic                             answer_flag,
  output logic                             table_full
);

  otl_pkg::entry_t  mem [otl_pkg::ENTRIES];
  otl_pkg::ptr_t    heads [otl_pkg::BUCKETS];

  otl_pkg::mode_t   mode_q;
  otl_pkg::name_t   id_q;
  otl_pkg::optype_t type_q;
  otl_pkg::level_t  level_q;
  otl_pkg::level_t  min_q;
  otl_pkg::bkt_t    bkt_q;
  otl_pkg::ptr_t    head_q;
  otl_pkg::ptr_t    cur;
  otl_pkg::ptr_t    steps;
  otl_pkg::ptr_t    used;
  logic             found;
  otl_pkg::entry_t  rd_q;

  otl_pkg::bkt_t    in_bkt;
  otl_pkg::pos_t    pos;
  logic             type_ok;
  logic             is_add;
  logic             pool_empty;
  logic             do_alloc;
  logic             do_write;
  logic             set_full;
  otl_pkg::entry_t  base;
  otl_pkg::entry_t  wr_data;
  otl_pkg::idx_t    wr_addr;
  otl_pkg::level_t  lvl_found;
  otl_pkg::level_t  q_level;
  otl_pkg::level_t  res_level_c;
  logic             flag_c;

  assign in_bkt = otl_pkg::BKT_W'(name_id % otl_pkg::BUCKETS);

  // input capture and chain pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q  <= otl_pkg::mode_t'(mode);
      id_q    <= name_id;
      type_q  <= op_type;
      level_q <= op_level;
      min_q   <= min_level;
      bkt_q   <= in_bkt;
      head_q  <= heads[in_bkt];
      cur     <= heads[in_bkt];
      steps   <= '0;
    end else if (cmd.advance) begin
      cur   <= rd_q.next;
      steps <= steps + otl_pkg::PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.accept) begin
      found <= 1'b0;
    end else if (cmd.hit) begin
      found <= 1'b1;
    end
  end

  assign sts.ptr_ok     = (cur < used) && (steps < used);
  assign sts.name_match = (rd_q.name == id_q);
  assign sts.out_free   = !out_valid || out_ready;

  // update decode
  assign pos        = otl_pkg::pos_of(type_q);
  assign type_ok    = (type_q <= otl_pkg::OP_YF);
  assign is_add     = (mode_q == otl_pkg::MODE_ADD) && type_ok;
  assign pool_empty = (used == otl_pkg::NIL);
  assign do_alloc   = cmd.act && is_add && !found && !pool_empty;
  assign set_full   = is_add && !found && pool_empty;
  assign do_write   = cmd.act && is_add && (found || !pool_empty);

  always_comb begin
    if (found) begin
      base = rd_q;
    end else begin
      base        = '0;
      base.name   = id_q;
      base.next   = head_q;
    end
    wr_data             = base;
    wr_data.levels[pos] = level_q;
    wr_data.types[pos]  = (level_q != '0) ? (type_q + otl_pkg::TYPE_W'(1)) : '0;
    wr_addr = found ? cur[otl_pkg::IDX_W-1:0] : used[otl_pkg::IDX_W-1:0];
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_read) begin
      rd_q <= mem[cur[otl_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < otl_pkg::BUCKETS; b++) begin
        heads[b] <= otl_pkg::NIL;
      end
      used <= '0;
    end else if (do_alloc) begin
      heads[bkt_q] <= used;
      used         <= used + otl_pkg::PTR_W'(1);
    end
  end

  // lookup results
  always_comb begin
    lvl_found   = rd_q.levels[pos];
    q_level     = (rd_q.levels[otl_pkg::POS_INFIX] != '0) ?
                  rd_q.levels[otl_pkg::POS_INFIX] : rd_q.levels[otl_pkg::POS_SUFFIX];
    res_level_c = '0;
    flag_c      = 1'b0;
    case (mode_q)
      otl_pkg::MODE_LEVEL: begin
        if (type_ok && found &&
            (rd_q.types[pos] == (type_q + otl_pkg::TYPE_W'(1)))) begin
          res_level_c = lvl_found;
          flag_c      = (lvl_found != '0);
        end
      end
      otl_pkg::MODE_QUERY: begin
        flag_c = found && (q_level >= min_q);
      end
      default: begin
        res_level_c = '0;
        flag_c      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.act) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act) begin
      result_level <= res_level_c;
      answer_flag  <= flag_c;
      table_full   <= set_full;
    end
  end

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= otl_pkg::NIL)
    else $error("entry count beyond pool size");

  a_used_only_on_act: assert property (@(posedge clk) disable iff (rst)
    !cmd.act |=> used == $past(used))
    else $error("entry count changed outside an update");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !answer_flag && result_level == '0)
    else $error("full flag with a lookup answer");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_read |-> cur < used)
    else $error("chain read beyond allocated entries");
`endif

endmodule
`default_nettype wire
